>>> sv/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned HDR_BYTES  = 20;
  localparam int unsigned HDR_CNT_W  = 5;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_BYTES - 1);

  // header byte positions where each field starts
  localparam logic [HDR_CNT_W-1:0] POS_VERSION = HDR_CNT_W'(4);
  localparam logic [HDR_CNT_W-1:0] POS_TYPE    = HDR_CNT_W'(6);
  localparam logic [HDR_CNT_W-1:0] POS_REQUEST = HDR_CNT_W'(8);
  localparam logic [HDR_CNT_W-1:0] POS_LENGTH  = HDR_CNT_W'(16);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAGIC_WORD       = 2'd0,
    REG_PROTOCOL_VERSION = 2'd1,
    REG_MAX_PAYLOAD      = 2'd2
  } cfg_reg_t;

  localparam logic [31:0] MAGIC_WORD_RST  = 32'd0;
  localparam logic [15:0] VERSION_RST     = 16'd1;
  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } result_kind_t;

  typedef enum logic [1:0] {
    ERR_MAGIC   = 2'd0,
    ERR_VERSION = 2'd1,
    ERR_LENGTH  = 2'd2
  } error_code_t;

  typedef struct packed {
    result_kind_t kind;
    logic [15:0]  header_version;
    logic [15:0]  message_type;
    logic [63:0]  request_id;
    logic [31:0]  payload_length;
    logic [7:0]   payload_byte;
    error_code_t  error_code;
    logic         last_of_packet;
  } result_t;

endpackage

>>> sv/lpd_skid.sv
// ----------------------------------------------------------------------------
// lpd_skid
// Result register with one skid entry between the parser and the output port.
// ----------------------------------------------------------------------------
module lpd_skid (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lpd_pkg::result_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lpd_pkg::result_t out_data
);
  import lpd_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_ready || !main_valid) begin
        if (skid_valid) begin
          main_data  <= skid_data;
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          main_data  <= in_data;
          main_valid <= in_valid;
        end
      end else if (in_valid && !skid_valid) begin
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

>>> sv/length_prefixed_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_core
// Collects a 20-byte big-endian header, checks magic, version and length,
// then streams the payload bytes, one result per byte.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// input     in_valid / in_ready    data_byte, clear_parser
// output    out_valid / out_ready  result_kind .. last_of_packet
// config    cfg_write              cfg_index, cfg_data
//
// One byte per cycle while in_ready is high; each transaction passes through the shift
// registers and byte counter into the result register.
// Results are registered in the skid's main entry (or its skid entry while the output stalls).
// A one-entry skid lets one more result be accepted while the output stalls;
// in_ready drops only while both result entries are held.
// rst is synchronous and restores the configuration registers and parser state.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lpd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      data_byte,
  input  logic                            clear_parser,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      result_kind,
  output logic [15:0]                     header_version,
  output logic [15:0]                     message_type,
  output logic [63:0]                     request_id,
  output logic [31:0]                     payload_length,
  output logic [7:0]                      payload_byte,
  output logic [1:0]                      error_code,
  output logic                            last_of_packet
);
  import lpd_pkg::*;

  logic [31:0] magic_word;
  logic [15:0] protocol_version;
  logic [31:0] max_payload;

  logic                 in_payload;
  logic [HDR_CNT_W-1:0] header_count;
  logic [31:0]          magic_shift;
  logic [15:0]          version_shift;
  logic [15:0]          type_shift;
  logic [63:0]          request_shift;
  logic [31:0]          length_shift;
  logic [31:0]          bytes_remaining;

  logic        accept;
  logic        byte_take;
  logic        hdr_done;
  logic [31:0] length_next;
  logic        bad_magic;
  logic        bad_version;
  logic        bad_length;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word       <= MAGIC_WORD_RST;
      protocol_version <= VERSION_RST;
      max_payload      <= MAX_PAYLOAD_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAGIC_WORD:       magic_word       <= cfg_data;
        REG_PROTOCOL_VERSION: protocol_version <= cfg_data[15:0];
        REG_MAX_PAYLOAD:      max_payload      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept      = in_valid && in_ready;
  assign byte_take   = accept && !clear_parser;
  assign hdr_done    = !in_payload && (header_count == HDR_LAST);
  assign length_next = {length_shift[23:0], data_byte};
  assign bad_magic   = magic_shift != magic_word;
  assign bad_version = version_shift != protocol_version;
  assign bad_length  = length_next > max_payload;
  assign res_valid   = byte_take && (in_payload || hdr_done);

  always_comb begin
    res = '0;
    if (in_payload) begin
      res.kind           = KIND_PAYLOAD;
      res.payload_byte   = data_byte;
      res.last_of_packet = bytes_remaining == 32'd1;
    end else if (bad_magic || bad_version || bad_length) begin
      res.kind           = KIND_ERROR;
      res.last_of_packet = 1'b1;
      priority if (bad_magic)   res.error_code = ERR_MAGIC;
      else if (bad_version)     res.error_code = ERR_VERSION;
      else                      res.error_code = ERR_LENGTH;
    end else begin
      res.kind           = KIND_HEADER;
      res.header_version = version_shift;
      res.message_type   = type_shift;
      res.request_id     = request_shift;
      res.payload_length = length_next;
      res.last_of_packet = length_next == 32'd0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload      <= 1'b0;
      header_count    <= '0;
      bytes_remaining <= '0;
    end else if (accept && clear_parser) begin
      in_payload      <= 1'b0;
      header_count    <= '0;
      bytes_remaining <= '0;
    end else if (byte_take) begin
      if (in_payload) begin
        bytes_remaining <= bytes_remaining - 32'd1;
        if (bytes_remaining == 32'd1) begin
          in_payload <= 1'b0;
        end
      end else if (hdr_done) begin
        header_count <= '0;
        if (!bad_magic && !bad_version && !bad_length && length_next != 32'd0) begin
          in_payload      <= 1'b1;
          bytes_remaining <= length_next;
        end
      end else begin
        header_count <= header_count + HDR_CNT_W'(1);
      end
    end
  end

  // header shift registers, fully rewritten by every header
  always_ff @(posedge clk) begin
    if (byte_take && !in_payload) begin
      priority if (header_count < POS_VERSION) magic_shift <= {magic_shift[23:0], data_byte};
      else if (header_count < POS_TYPE)    version_shift <= {version_shift[7:0], data_byte};
      else if (header_count < POS_REQUEST) type_shift    <= {type_shift[7:0], data_byte};
      else if (header_count < POS_LENGTH)  request_shift <= {request_shift[55:0], data_byte};
      else                                 length_shift  <= length_next;
    end
  end

  lpd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (in_ready),
    .in_data   (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign result_kind    = out_res.kind;
  assign header_version = out_res.header_version;
  assign message_type   = out_res.message_type;
  assign request_id     = out_res.request_id;
  assign payload_length = out_res.payload_length;
  assign payload_byte   = out_res.payload_byte;
  assign error_code     = out_res.error_code;
  assign last_of_packet = out_res.last_of_packet;

  a_payload_no_count: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> header_count == '0)
    else $error("header count nonzero during payload");

  a_payload_remaining: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> bytes_remaining != 32'd0)
    else $error("payload active with nothing remaining");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_ERROR |-> last_of_packet)
    else $error("error result without last_of_packet");

  a_end_of_payload: assert property (@(posedge clk) disable iff (rst)
    byte_take && in_payload && bytes_remaining == 32'd1 |=> !in_payload)
    else $error("payload did not end after final byte");

endmodule

>>> tb/length_prefixed_packet_deframer_check.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_check
// Watches the config port and both streaming channels of the deframer. Every
// accepted input transaction goes through a bit-accurate header/payload
// parser, and the results it gives are queued. Every accepted output
// transaction is compared field by field against the oldest queued result.
// The mismatch count and the number of results still awaited go to the top.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           clear_parser,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [1:0]                     result_kind,
  input  logic [15:0]                    header_version,
  input  logic [15:0]                    message_type,
  input  logic [63:0]                    request_id,
  input  logic [31:0]                    payload_length,
  input  logic [7:0]                     payload_byte,
  input  logic [1:0]                     error_code,
  input  logic                           last_of_packet,
  output int unsigned                    mismatch_count,
  output int unsigned                    pending
);
  import lpd_pkg::*;

  logic [31:0]          magic_word_q;
  logic [15:0]          version_q;
  logic [31:0]          max_payload_q;

  logic                 in_payload;
  logic [HDR_CNT_W-1:0] hdr_count;
  logic [31:0]          magic_acc;
  logic [15:0]          version_acc;
  logic [15:0]          type_acc;
  logic [63:0]          request_acc;
  logic [31:0]          length_acc;
  logic [31:0]          remaining;

  result_t              awaited_results[$];
  result_t              oldest;

  task automatic clear_parse_state();
    in_payload  = 1'b0;
    hdr_count   = '0;
    magic_acc   = '0;
    version_acc = '0;
    type_acc    = '0;
    request_acc = '0;
    length_acc  = '0;
    remaining   = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic clr);
    result_t     r;
    logic [31:0] len_hold;
    r = '0;
    if (clr) begin
      clear_parse_state();
    end else if (in_payload) begin
      remaining = remaining - 32'd1;
      r.kind = KIND_PAYLOAD;
      r.payload_byte = b;
      if (remaining == 32'd0) begin
        in_payload = 1'b0;
        r.last_of_packet = 1'b1;
      end
      awaited_results.push_back(r);
    end else begin
      if (hdr_count < POS_VERSION) begin
        magic_acc = {magic_acc[23:0], b};
      end else if (hdr_count < POS_TYPE) begin
        version_acc = {version_acc[7:0], b};
      end else if (hdr_count < POS_REQUEST) begin
        type_acc = {type_acc[7:0], b};
      end else if (hdr_count < POS_LENGTH) begin
        request_acc = {request_acc[55:0], b};
      end else begin
        length_acc = {length_acc[23:0], b};
      end
      if (hdr_count != HDR_LAST) begin
        hdr_count = hdr_count + HDR_CNT_W'(1);
      end else begin
        if (magic_acc != magic_word_q) begin
          r.kind = KIND_ERROR;
          r.error_code = ERR_MAGIC;
          r.last_of_packet = 1'b1;
        end else if (version_acc != version_q) begin
          r.kind = KIND_ERROR;
          r.error_code = ERR_VERSION;
          r.last_of_packet = 1'b1;
        end else if (length_acc > max_payload_q) begin
          r.kind = KIND_ERROR;
          r.error_code = ERR_LENGTH;
          r.last_of_packet = 1'b1;
        end else begin
          r.kind = KIND_HEADER;
          r.header_version = version_acc;
          r.message_type = type_acc;
          r.request_id = request_acc;
          r.payload_length = length_acc;
          r.last_of_packet = (length_acc == 32'd0);
        end
        len_hold = length_acc;
        clear_parse_state();
        if (r.kind == KIND_HEADER && len_hold != 32'd0) begin
          in_payload = 1'b1;
          remaining = len_hold;
        end
        awaited_results.push_back(r);
      end
    end
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      magic_word_q = MAGIC_WORD_RST;
      version_q = VERSION_RST;
      max_payload_q = MAX_PAYLOAD_RST;
      clear_parse_state();
      awaited_results.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MAGIC_WORD:       magic_word_q = cfg_data;
          REG_PROTOCOL_VERSION: version_q = cfg_data[15:0];
          REG_MAX_PAYLOAD:      max_payload_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        deframe_byte(data_byte, clear_parser);
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d byte %0h",
                   $time, result_kind, payload_byte);
          mismatch_count++;
        end else begin
          oldest = awaited_results.pop_front();
          compare_field("result_kind", 64'(oldest.kind), 64'(result_kind));
          compare_field("header_version", 64'(oldest.header_version),
                        64'(header_version));
          compare_field("message_type", 64'(oldest.message_type), 64'(message_type));
          compare_field("request_id", oldest.request_id, request_id);
          compare_field("payload_length", 64'(oldest.payload_length),
                        64'(payload_length));
          compare_field("payload_byte", 64'(oldest.payload_byte), 64'(payload_byte));
          compare_field("error_code", 64'(oldest.error_code), 64'(error_code));
          compare_field("last_of_packet", 64'(oldest.last_of_packet),
                        64'(last_of_packet));
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

>>> tb/length_prefixed_packet_deframer_core_test.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_core_test
// Drives byte streams into the deframer: directed frames for the header
// checks and their priority, empty and short payloads, clears in every
// parser state and register writes, then random frames (mostly well formed,
// some corrupt, truncated or noise) under several register settings and
// three idling regimes. The checker module predicts and compares results.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_core_test;
  import lpd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned TARGET_BYTES = 1500;
  localparam int unsigned PHASES       = 6;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            data_byte;
  logic                  clear_parser;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            result_kind;
  logic [15:0]           header_version;
  logic [15:0]           message_type;
  logic [63:0]           request_id;
  logic [31:0]           payload_length;
  logic [7:0]            payload_byte;
  logic [1:0]            error_code;
  logic                  last_of_packet;

  int unsigned           mismatch_count;
  int unsigned           pending;
  int unsigned           in_idle_pct  = 0;
  int unsigned           out_idle_pct = 0;
  int unsigned           bytes_sent   = 0;
  int unsigned           stall_cycles = 0;

  logic [31:0]           cur_magic;
  logic [15:0]           cur_version;
  logic [31:0]           cur_max;

  length_prefixed_packet_deframer_core DUT (.*);

  length_prefixed_packet_deframer_check result_check (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic clr);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    clear_parser <= clr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_header(input logic [31:0] magic, input logic [15:0] ver,
                             input logic [15:0] mtype, input logic [63:0] id,
                             input logic [31:0] len);
    logic [159:0] hdr;
    hdr = {magic, ver, mtype, id, len};
    for (int i = 0; i < HDR_BYTES; i++) begin
      send_byte(hdr[159 - 8*i -: 8], 1'b0);
    end
  endtask

  task automatic send_payload(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  // hold input idle until every awaited result has been delivered
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MAGIC_WORD:       cur_magic = val;
      REG_PROTOCOL_VERSION: cur_version = val[15:0];
      REG_MAX_PAYLOAD:      cur_max = val;
      default: ;
    endcase
  endtask

  task automatic random_frame();
    int unsigned pick;
    int unsigned lim;
    int unsigned n;
    logic [31:0] len;
    logic [63:0] id;
    pick = $urandom_range(99);
    id = {$urandom, $urandom};
    lim = (cur_max < 12) ? cur_max : 12;
    if (pick < 70 || (pick >= 86 && pick < 92 && cur_max == 32'hFFFF_FFFF)) begin
      len = $urandom_range(lim);
      if (cur_max <= 40 && $urandom_range(3) == 0) len = cur_max;
      send_header(cur_magic, cur_version, 16'($urandom_range(16'hFFFF)), id, len);
      send_payload(len);
    end else if (pick < 80) begin
      send_header(cur_magic ^ (32'd1 << $urandom_range(31)),
                  16'($urandom_range(16'hFFFF)),
                  16'($urandom_range(16'hFFFF)), id, $urandom);
    end else if (pick < 86) begin
      send_header(cur_magic, cur_version ^ (16'd1 << $urandom_range(15)),
                  16'($urandom_range(16'hFFFF)), id, $urandom);
    end else if (pick < 92) begin
      len = $urandom_range(1) ? cur_max + 32'd1 : $urandom_range(32'hFFFF_FFFF, cur_max + 1);
      send_header(cur_magic, cur_version, 16'($urandom_range(16'hFFFF)), id, len);
    end else if (pick < 96) begin
      if (cur_max == 0 || $urandom_range(1)) begin
        n = $urandom_range(19);
        send_payload(n);
      end else begin
        len = $urandom_range(lim, 1);
        send_header(cur_magic, cur_version, 16'($urandom_range(16'hFFFF)), id, len);
        send_payload($urandom_range(len - 1));
      end
      send_byte(8'($urandom_range(255)), 1'b1);
    end else begin
      send_payload($urandom_range(30, 1));
      send_byte(8'($urandom_range(255)), 1'b1);
    end
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    data_byte = '0;
    clear_parser = 1'b0;
    in_idle_pct = 9;
    out_idle_pct = 61;
    cur_magic = MAGIC_WORD_RST;
    cur_version = VERSION_RST;
    cur_max = MAX_PAYLOAD_RST;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_header(cur_magic, cur_version, 16'hFFFF, '1, 32'd0);
    send_header(cur_magic, cur_version, 16'h0000, '0, 32'd3);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_header(32'hFFFF_FFFF, cur_version, 16'h1234, {$urandom, $urandom}, 32'd1);
    send_header(cur_magic, 16'hFFFF, 16'h4321, {$urandom, $urandom}, 32'd1);
    send_header(32'h8000_0000, 16'h0000, 16'h0001, {$urandom, $urandom}, 32'hFFFF_FFFF);
    send_header(cur_magic, 16'h0000, 16'h0002, {$urandom, $urandom}, 32'hFFFF_FFFF);
    send_header(cur_magic, cur_version, 16'h0003, {$urandom, $urandom}, 32'hFFFF_FFFF);
    send_header(cur_magic, cur_version, 16'h0004, {$urandom, $urandom}, cur_max + 32'd1);
    send_payload(7);
    send_byte(8'hFF, 1'b1);
    send_header(cur_magic, cur_version, 16'h0005, {$urandom, $urandom}, 32'd6);
    send_payload(3);
    wait_drained();
    send_payload(3);
    send_header(cur_magic, cur_version, 16'h0006, {$urandom, $urandom}, 32'd5);
    send_payload(2);
    send_byte(8'h00, 1'b1);
    send_byte(8'hA5, 1'b1);
    send_header(cur_magic, cur_version, 16'h0007, {$urandom, $urandom}, 32'd1);
    send_payload(1);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_MAX_PAYLOAD, 32'd4);
    send_header(cur_magic, cur_version, 16'h0008, {$urandom, $urandom}, 32'd4);
    send_payload(4);
    send_header(cur_magic, cur_version, 16'h0009, {$urandom, $urandom}, 32'd5);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_MAGIC_WORD, 32'h0000_0000);
          write_reg(REG_PROTOCOL_VERSION, 32'h0000_0000);
          write_reg(REG_MAX_PAYLOAD, 32'h0000_0000);
        end
        1: begin
          write_reg(REG_MAGIC_WORD, 32'hFFFF_FFFF);
          write_reg(REG_PROTOCOL_VERSION, 32'h0000_FFFF);
          write_reg(REG_MAX_PAYLOAD, 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(REG_MAGIC_WORD, $urandom);
          write_reg(REG_PROTOCOL_VERSION, $urandom);
          write_reg(REG_MAX_PAYLOAD, $urandom_range(40, 1));
        end
      endcase
      if (p == 2) begin
        in_idle_pct = 61;
        out_idle_pct = 9;
      end
      if (p == 4) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      phase_end = bytes_sent + TARGET_BYTES / PHASES;
      while (bytes_sent < phase_end) random_frame();
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
